>>> hw/rtl/bresenham_edge_stepper_core_defines.svh
// ----------------------------------------------------------------------------
// Edge stepper assertion macros
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_EDGE_STEPPER_CORE_DEFINES_SVH
`define BRESENHAM_EDGE_STEPPER_CORE_DEFINES_SVH

// same-cycle implication
`define BES_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge stepper same-cycle check failed");

// next-cycle implication
`define BES_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge stepper next-cycle check failed");

`endif

>>> hw/rtl/bes_pkg.sv
// ----------------------------------------------------------------------------
// Edge stepper package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bes_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;

  localparam logic REQ_SETUP = 1'b0;

  typedef struct packed {
    logic capture;
    logic delta;
    logic commit;
    logic clamp;
    logic step;
    logic snap;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic flat;
    logic at_target;
  } sts_t;

endpackage

>>> hw/rtl/bes_ctrl.sv
// ----------------------------------------------------------------------------
// Edge stepper controller
// Sequences set-up and advance transactions and drives the datapath.
// ----------------------------------------------------------------------------
module bes_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          req_type,
  input  logic          out_free,
  input  bes_pkg::sts_t sts,
  output logic          in_ready,
  output bes_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DELTA  = 6'b000010,
    ST_COMMIT = 6'b000100,
    ST_CLAMP  = 6'b001000,
    ST_WALK   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (req_type == bes_pkg::REQ_SETUP) ? ST_DELTA : ST_CLAMP;
        end
      end
      ST_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.single) begin
          cmd.snap   = 1'b1;
          state_next = ST_DONE;
        end else if (sts.flat || sts.at_target) begin
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/bes_dp.sv
// ----------------------------------------------------------------------------
// Edge stepper datapath
// Edge state, working point and the one-step-per-cycle Bresenham update.
// ----------------------------------------------------------------------------
module bes_dp #(
  parameter int unsigned COORD_BITS = bes_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bes_pkg::cmd_t                cmd,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] target_y,
  output bes_pkg::sts_t                sts,
  output logic signed [COORD_BITS-1:0] new_x,
  output logic signed [COORD_BITS-1:0] new_y,
  output logic                         reached_end
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned MW = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 2;
  localparam int unsigned EW = COORD_BITS + 3;

  localparam logic [1:0] MODE_XMAJOR = 2'd0;
  localparam logic [1:0] MODE_YMAJOR = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] ex_in;
  logic signed [CW-1:0] ey_in;
  logic signed [CW-1:0] ty;
  logic        [CW-1:0] dx_abs;
  logic        [CW-1:0] dy_sat;

  logic                 step_dir;
  logic [1:0]           walk_mode;
  logic        [MW-1:0] major_twice;
  logic        [MW-1:0] minor_twice;
  logic signed [DW-1:0] diag_delta;
  logic signed [EW-1:0] error_term;
  logic signed [CW-1:0] edge_end_x;
  logic signed [CW-1:0] edge_end_y;

  logic signed [CW:0]   dx_diff;
  logic signed [CW:0]   dy_diff;
  logic        [CW-1:0] dx_abs_next;
  logic        [CW-1:0] dy_sat_next;
  logic                 dir_next;
  logic                 y_major;
  logic        [CW-1:0] big;
  logic        [CW-1:0] small_d;
  logic signed [EW-1:0] err_init;
  logic signed [DW-1:0] diag_init;
  logic [1:0]           mode_init;
  logic                 err_nonneg;
  logic                 x_move;
  logic                 y_inc;
  logic signed [CW-1:0] x_stepped;
  logic signed [EW-1:0] diag_ext;
  logic signed [EW-1:0] minor_ext;
  logic signed [CW-1:0] ty_clamped;

  assign dx_diff     = (CW+1)'(ex_in) - (CW+1)'(x);
  assign dy_diff     = (CW+1)'(ey_in) - (CW+1)'(y);
  assign dx_abs_next = dx_diff[CW] ? CW'(-dx_diff) : CW'(dx_diff);
  assign dy_sat_next = (!dy_diff[CW] && (dy_diff != '0)) ? CW'(dy_diff) : '0;
  assign dir_next    = dx_diff[CW] || (dx_diff == '0);

  assign y_major   = (dy_sat > dx_abs);
  assign big       = y_major ? dy_sat : dx_abs;
  assign small_d   = y_major ? dx_abs : dy_sat;
  assign err_init  = $signed(EW'({small_d, 1'b0}) - EW'(big));
  assign diag_init = $signed(DW'({small_d, 1'b0}) - DW'({big, 1'b0}));
  assign mode_init = (big == '0) ? MODE_SINGLE : (y_major ? MODE_YMAJOR : MODE_XMAJOR);

  assign err_nonneg = !error_term[EW-1];
  assign x_move     = (walk_mode == MODE_XMAJOR) || err_nonneg;
  assign y_inc      = (walk_mode == MODE_YMAJOR) || err_nonneg;
  assign x_stepped  = step_dir ? (x - CW'(1)) : (x + CW'(1));
  assign diag_ext   = EW'(diag_delta);
  assign minor_ext  = $signed(EW'(minor_twice));
  assign ty_clamped = (ty < edge_end_y) ? ty : edge_end_y;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x     <= point_x;
      y     <= point_y;
      ex_in <= end_x;
      ey_in <= end_y;
      ty    <= target_y;
    end else if (cmd.clamp) begin
      ty <= ty_clamped;
    end else if (cmd.snap) begin
      x <= edge_end_x;
    end else if (cmd.step) begin
      if (x_move) begin
        x <= x_stepped;
      end
      if (y_inc) begin
        y <= y + CW'(1);
      end
    end
    if (cmd.delta) begin
      dx_abs <= dx_abs_next;
      dy_sat <= dy_sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_dir    <= 1'b0;
      walk_mode   <= MODE_XMAJOR;
      major_twice <= '0;
      minor_twice <= '0;
      diag_delta  <= '0;
      error_term  <= '0;
      edge_end_x  <= '0;
      edge_end_y  <= '0;
    end else begin
      if (cmd.delta) begin
        step_dir <= dir_next;
      end
      if (cmd.commit) begin
        walk_mode   <= mode_init;
        major_twice <= {big, 1'b0};
        minor_twice <= {small_d, 1'b0};
        diag_delta  <= diag_init;
        error_term  <= err_init;
        edge_end_x  <= ex_in;
        edge_end_y  <= ey_in;
      end else if (cmd.step) begin
        error_term <= error_term + (err_nonneg ? diag_ext : minor_ext);
      end
    end
  end

  assign sts.single    = (walk_mode == MODE_SINGLE);
  assign sts.flat      = (walk_mode == MODE_XMAJOR) && (minor_twice == '0);
  assign sts.at_target = !(y < ty);

  assign new_x       = x;
  assign new_y       = y;
  assign reached_end = sts.single || (y == edge_end_y);

endmodule

>>> hw/rtl/bresenham_edge_stepper_core.sv
// Set-up: no result; the input is ready again once the DELTA and COMMIT states have run.
// Advance: the result follows the CLAMP, WALK and DONE states, n = Bresenham steps taken.
// n is one per row on y-major edges; x-major edges add one step per extra x pixel.
// The datapath takes one step per cycle; the output register frees the input side.
// Reset (rst, synchronous, active high) clears the edge state to a flat x-major edge.
// ----------------------------------------------------------------------------
// Bresenham edge stepper core
// Rasterizer edge walker: set-up stores an edge, advance steps it to a row.
// ----------------------------------------------------------------------------
`include "bresenham_edge_stepper_core_defines.svh"

module bresenham_edge_stepper_core #(
  parameter int unsigned COORD_BITS = bes_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W      = ((5 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // point_x, point_y, end_x, end_y, target_y
  input  logic             s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // new_x, new_y
  output logic             m_axis_tuser   // reached_end
);

  localparam int unsigned CW = COORD_BITS;

  bes_pkg::cmd_t cmd;
  bes_pkg::sts_t sts;

  logic                 s_accept;
  logic                 out_free;
  logic signed [CW-1:0] dp_x;
  logic signed [CW-1:0] dp_y;
  logic                 dp_reached;
  logic signed [CW-1:0] res_x;
  logic signed [CW-1:0] res_y;
  logic                 res_reached;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  bes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .req_type (s_axis_tuser),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  bes_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .point_x     ($signed(s_axis_tdata[0*CW +: CW])),
    .point_y     ($signed(s_axis_tdata[1*CW +: CW])),
    .end_x       ($signed(s_axis_tdata[2*CW +: CW])),
    .end_y       ($signed(s_axis_tdata[3*CW +: CW])),
    .target_y    ($signed(s_axis_tdata[4*CW +: CW])),
    .sts         (sts),
    .new_x       (dp_x),
    .new_y       (dp_y),
    .reached_end (dp_reached)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_x       <= dp_x;
      res_y       <= dp_y;
      res_reached <= dp_reached;
    end
  end

  assign m_axis_tdata = OUT_W'({res_y, res_x});
  assign m_axis_tuser = res_reached;

  `BES_ASSERT_IMPLY(a_load_when_free, cmd.load, out_free)
  `BES_ASSERT_IMPLY(a_ready_no_work, s_axis_tready, !cmd.step && !cmd.load)
  `BES_ASSERT_NEXT(a_setup_no_result, s_accept && (s_axis_tuser == bes_pkg::REQ_SETUP), !cmd.load)
  `BES_ASSERT_NEXT(a_single_reaches, cmd.load && sts.single, m_axis_tvalid && m_axis_tuser)

endmodule

>>> tb/bresenham_edge_stepper_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham edge stepper core testbench
// Streams set-up and advance transactions into the core, runs its own
// Bresenham edge walker on every accepted transaction and checks each
// returned point, field by field, in order.
// ----------------------------------------------------------------------------
module bresenham_edge_stepper_core_test;

  localparam logic REQ_ADVANCE  = ~bes_pkg::REQ_SETUP;
  localparam int   ITEM_GOAL    = 950;
  localparam int   CYCLE_LIMIT  = 2_000_000;
  localparam int   DRAIN_CYCLES = 64;
  localparam int   IDLE_PCT     = 16;

  typedef enum logic [1:0] {
    WALK_XMAJOR = 2'd0,
    WALK_YMAJOR = 2'd1,
    WALK_POINT  = 2'd2
  } walk_mode_e;

  typedef struct {
    logic               req;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [15:0] ty;
  } edge_req_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               at_end;
  } edge_point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // point_x, point_y, end_x, end_y, target_y
  logic        s_axis_tuser = 1'b0;  // req_type
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;  // new_x, new_y
  wire         m_axis_tuser;  // reached_end

  edge_req_t   pending[$];
  edge_req_t   on_bus;
  edge_point_t points_due[$];
  int          items_sent = 0;
  logic        in_fire = 1'b0;
  int          errors = 0;
  wire         calm = (items_sent >= 350) && (items_sent < 550);
  int          plan_dx = 0;
  int          plan_dy = 0;

  logic               walk_neg = 1'b0;
  walk_mode_e         walk_mode = WALK_XMAJOR;
  int                 major_2x = 0;
  int                 minor_2x = 0;
  int                 bres_err = 0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;

  always #6 clk = ~clk;

  bresenham_edge_stepper_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic logic [15:0] nudge_x(logic [15:0] x, int n);
    return walk_neg ? x - 16'(n) : x + 16'(n);
  endfunction

  function automatic void walk_edge(edge_req_t r);
    int          dx;
    int          dy;
    int          row;
    int          yy;
    int          k;
    int          e;
    logic [15:0] x;
    edge_point_t p;
    if (r.req == bes_pkg::REQ_SETUP) begin
      dx = (r.ex > r.px) ? int'(r.ex) - int'(r.px) : int'(r.px) - int'(r.ex);
      dy = (r.ey > r.py) ? int'(r.ey) - int'(r.py) : 0;
      walk_neg = !(r.px < r.ex);
      end_x = r.ex;
      end_y = r.ey;
      walk_mode = (dy > dx) ? WALK_YMAJOR : WALK_XMAJOR;
      major_2x = 2 * ((dy > dx) ? dy : dx);
      minor_2x = 2 * ((dy > dx) ? dx : dy);
      bres_err = minor_2x - major_2x / 2;
      if (major_2x == 0) begin
        walk_mode = WALK_POINT;
      end
    end else if (walk_mode == WALK_POINT) begin
      p.x = end_x;
      p.y = r.py;
      p.at_end = 1'b1;
      points_due.push_back(p);
    end else begin
      yy = (r.ty < end_y) ? int'(r.ty) : int'(end_y);
      x = r.px;
      row = r.py;
      e = bres_err;
      if (walk_mode == WALK_YMAJOR) begin
        while (row < yy) begin
          if (e >= 0) begin
            x = nudge_x(x, 1);
            e -= major_2x;
          end
          row++;
          e += minor_2x;
        end
      end else if (minor_2x > 0) begin
        while (row < yy) begin
          // catch up on the columns owed before the row step
          if (e < 0) begin
            k = (minor_2x - e - 1) / minor_2x;
            x = nudge_x(x, k);
            e += k * minor_2x;
          end
          row++;
          e += minor_2x - major_2x;
          x = nudge_x(x, 1);
        end
      end
      bres_err = e;
      p.x = x;
      p.y = 16'(row);
      p.at_end = (row == end_y);
      points_due.push_back(p);
    end
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic void queue_setup(int px, int py, int ex, int ey);
    edge_req_t r;
    r.req = bes_pkg::REQ_SETUP;
    r.px = 16'(px);
    r.py = 16'(py);
    r.ex = 16'(ex);
    r.ey = 16'(ey);
    r.ty = 16'($urandom);
    pending.push_back(r);
    plan_dx = (ex > px) ? ex - px : px - ex;
    plan_dy = (ey > py) ? ey - py : 0;
  endfunction

  function automatic void queue_advance(int px, int py, int ty);
    edge_req_t r;
    r.req = REQ_ADVANCE;
    r.px = 16'(px);
    r.py = 16'(py);
    r.ex = 16'($urandom);
    r.ey = 16'($urandom);
    r.ty = 16'(ty);
    pending.push_back(r);
  endfunction

  always @(negedge clk) begin : drive
    edge_req_t nxt;
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending.pop_front();
        on_bus <= nxt;
        s_axis_tdata <= {nxt.ty, nxt.ey, nxt.ex, nxt.py, nxt.px};
        s_axis_tuser <= nxt.req;
        s_axis_tvalid <= 1'b1;
        items_sent <= items_sent + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    edge_point_t want;
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (points_due.size() == 0) begin
        $display("t=%0t unexpected result x=%0d y=%0d reached_end=%0b", $time,
                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]), m_axis_tuser);
        errors++;
      end else begin
        want = points_due.pop_front();
        if (m_axis_tdata[15:0] !== want.x) begin
          $display("t=%0t new_x expected %0d got %0d", $time, want.x,
                   $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== want.y) begin
          $display("t=%0t new_y expected %0d got %0d", $time, want.y,
                   $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tuser !== want.at_end) begin
          $display("t=%0t reached_end expected %0b got %0b", $time, want.at_end,
                   m_axis_tuser);
          errors++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      walk_edge(on_bus);
    end
  end

  initial begin : run
    int sx;
    int sy;
    int ex;
    int ey;
    int dx;
    int x;
    int y;
    int ty;
    // advance before any edge is loaded
    queue_advance(5, -3, 10);
    queue_advance(-32768, 0, 32767);
    // single point
    queue_setup(7, 7, 7, 7);
    queue_advance(100, 3, -32768);
    // end above start, flat with target behind
    queue_setup(0, 10, 5, 2);
    queue_advance(0, 10, 20);
    // vertical, target clamped to end row
    queue_setup(3, 0, 3, 5);
    queue_advance(3, 0, 9);
    // steep, stepping left, with a target behind in between
    queue_setup(10, 0, 4, 9);
    queue_advance(10, 0, 4);
    queue_advance(8, 4, 2);
    queue_advance(8, 4, 20);
    // shallow, stepping left
    queue_setup(50, 0, 10, 3);
    queue_advance(50, 0, 1);
    queue_advance(37, 1, 3);
    // x wraps past the top of the range
    queue_setup(0, 0, 5, 2);
    queue_advance(32766, 0, 2);
    // full-width x-major edge
    queue_setup(-32768, -32768, 32767, -32767);
    queue_advance(-32768, -32768, -32767);
    // full-width diagonal
    queue_setup(32767, -32768, -32768, 32767);
    queue_advance(32767, -32768, -32765);
    // full-height y-major edge, finish on the top row
    queue_setup(0, -32768, 1, 32767);
    queue_advance(0, 32765, 32767);

    while (pending.size() < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 75) begin
        // well-formed edge walked row group by row group
        sx = int'($urandom_range(0, 64000)) - 32000;
        sy = int'($urandom_range(0, 64000)) - 32000;
        dx = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 300 : 30);
        ex = $urandom_range(0, 1) ? sx + dx : sx - dx;
        ey = sy + int'($urandom_range(0, 24));
        queue_setup(sx, sy, ex, ey);
        y = sy;
        while (y < ey) begin
          if ($urandom_range(0, 9) == 0) begin
            ty = ey + int'($urandom_range(0, 5));
          end else begin
            ty = y + int'($urandom_range(0, 3));
          end
          x = sx + (ex - sx) * (y - sy) / (ey - sy);
          queue_advance(x, y, ty);
          y = (ty < ey) ? ty : ey;
        end
        queue_advance(ex, y, y + int'($urandom_range(0, 4)));
      end else begin
        if ($urandom_range(0, 1)) begin
          queue_setup(rnd16(), rnd16(), rnd16(), rnd16());
        end
        repeat ($urandom_range(1, 3)) begin
          y = rnd16();
          // take a couple of row steps only where each row stays short, else aim at or behind the row
          if ($urandom_range(0, 1) && (plan_dy == 0 || plan_dx <= 64 * plan_dy)) begin
            ty = y + int'($urandom_range(0, 2));
            if (ty > 32767) begin
              ty = 32767;
            end
          end else begin
            ty = y - int'($urandom_range(0, y + 32768));
          end
          queue_advance(rnd16(), y, ty);
        end
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (pending.size() != 0 || s_axis_tvalid || points_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bresenham_edge_stepper_core_test: done, clean");
    end else begin
      $display("bresenham_edge_stepper_core_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("t=%0t timeout", $time);
    $display("bresenham_edge_stepper_core_test: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bes_pkg.sv
hw/rtl/bes_ctrl.sv
hw/rtl/bes_dp.sv
hw/rtl/bresenham_edge_stepper_core.sv
tb/bresenham_edge_stepper_core_test.sv
